// ===== src/curvature_to_false_color_core_macros.svh =====
// Assertion helpers for the false color core checker.
`ifndef CURVATURE_TO_FALSE_COLOR_CORE_MACROS_SVH
`define CURVATURE_TO_FALSE_COLOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfc checker: property failed");

// next-cycle implication
`define CFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfc checker: property failed");

`endif

// ===== src/cfc_pkg.sv =====
package cfc_pkg;

  // config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPING    = 2'd2;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [33:0] TEN_Q30 = 34'h2_8000_0000;
  localparam int unsigned SERIES_TERMS = 14;
  localparam int unsigned LOG_STEPS = 32;

  // one log2 lane: Q31 mantissa and fraction bits collected so far
  typedef struct packed {
    logic [31:0] m;
    logic [31:0] f;
  } lane_t;

  // flags riding along with each word
  typedef struct packed {
    logic err;   // upper bound below lower bound
    logic eq;    // empty range
    logic neg;   // normalized value negative
    logic zero;  // normalized value exactly zero
  } side_t;

  // one squaring step of the log2 fraction
  function automatic lane_t log_sq_step(lane_t a);
    logic [63:0] sq;
    lane_t r;
    sq = {32'd0, a.m} * {32'd0, a.m};
    if (sq[63]) begin
      r.m = sq[63:32];
      r.f = {a.f[30:0], 1'b1};
    end else begin
      r.m = sq[62:31];
      r.f = {a.f[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== src/cfc_log_step.sv =====
module cfc_log_step #(
  parameter int PW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  cfc_pkg::lane_t   d_i,
  input  cfc_pkg::lane_t   a_i,
  input  logic [PW-1:0]    pd_i,
  input  logic [PW-1:0]    pa_i,
  input  cfc_pkg::side_t   side_i,
  output logic             valid_o,
  output cfc_pkg::lane_t   d_o,
  output cfc_pkg::lane_t   a_o,
  output logic [PW-1:0]    pd_o,
  output logic [PW-1:0]    pa_o,
  output cfc_pkg::side_t   side_o
);

  logic           valid_r;
  cfc_pkg::lane_t d_r, a_r;
  logic [PW-1:0]  pd_r, pa_r;
  cfc_pkg::side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // two lanes squared side by side
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= cfc_pkg::log_sq_step(d_i);
      a_r    <= cfc_pkg::log_sq_step(a_i);
      pd_r   <= pd_i;
      pa_r   <= pa_i;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;
  assign a_o     = a_r;
  assign pd_o    = pd_r;
  assign pa_o    = pa_r;
  assign side_o  = side_r;

endmodule

// ===== src/cfc_horner_step.sv =====
module cfc_horner_step #(
  parameter int K = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  logic [29:0]    x_i,
  input  logic [30:0]    p_i,
  input  logic [4:0]     q_i,
  input  cfc_pkg::side_t side_i,
  output logic           valid_o,
  output logic [29:0]    x_o,
  output logic [30:0]    p_o,
  output logic [4:0]     q_o,
  output cfc_pkg::side_t side_o
);

  // floor(t / K) as (t * MAGIC) >> 34, exact for t below 2^30
  localparam logic [63:0] MAGIC_64 = ((64'd1 << 34) + 64'(K) - 64'd1) / 64'(K);
  localparam logic [34:0] MAGIC = MAGIC_64[34:0];

  logic           v_a_r, v_b_r;
  logic [29:0]    x_a_r, x_b_r, t_a_r;
  logic [4:0]     q_a_r, q_b_r;
  cfc_pkg::side_t side_a_r, side_b_r;
  logic [30:0]    p_b_r;

  logic [60:0]    xp;
  logic [64:0]    qp;

  assign xp = 61'(x_i) * 61'(p_i);
  assign qp = 65'(t_a_r) * 65'(MAGIC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else if (en) begin
      v_a_r <= valid_i;
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a_r    <= xp[59:30];
      x_a_r    <= x_i;
      q_a_r    <= q_i;
      side_a_r <= side_i;
      p_b_r    <= cfc_pkg::ONE_Q30 - 31'(qp[63:34]);
      x_b_r    <= x_a_r;
      q_b_r    <= q_a_r;
      side_b_r <= side_a_r;
    end
  end

  assign valid_o = v_b_r;
  assign x_o     = x_b_r;
  assign p_o     = p_b_r;
  assign q_o     = q_b_r;
  assign side_o  = side_b_r;

endmodule

// ===== src/cfc_channel.sv =====
module cfc_channel #(
  parameter int CW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [30:0]   f_i,
  input  logic          err_i,
  output logic [CW-1:0] color_o
);

  localparam int SUMW = 36 + CW;
  localparam int NW   = CW + 4;
  localparam int S5   = NW + 3;
  localparam logic [63:0] M5_64 = ((64'd1 << S5) + 64'd4) / 64'd5;
  localparam logic [S5-1:0] M5 = M5_64[S5-1:0];
  localparam logic [NW-1:0] LIM = NW'({CW{1'b1}});

  logic [34:0]      a;
  logic [SUMW-1:0]  sum;
  logic [NW-1:0]    w_r;
  logic             err_r;
  logic [NW+S5-1:0] prod;
  logic [NW-1:0]    v;
  logic [CW-1:0]    color_r;

  // (1 + 18 f) / 20 scaled: divide by 2^32 here, by 5 next
  assign a   = 35'(cfc_pkg::ONE_Q30) + (35'(f_i) << 4) + (35'(f_i) << 1);
  assign sum = (SUMW'(a) << CW) + SUMW'(cfc_pkg::TEN_Q30);

  assign prod = (NW + S5)'(w_r) * (NW + S5)'(M5);
  assign v    = prod[NW+S5-1:S5];

  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= sum[SUMW-1:32];
      err_r <= err_i;
      if (err_r) begin
        color_r <= '0;
      end else if (v > LIM) begin
        color_r <= '1;
      end else begin
        color_r <= v[CW-1:0];
      end
    end
  end

  assign color_o = color_r;

endmodule

// ===== src/curvature_to_false_color_core.sv =====
// Throughput: one word per cycle while the output skid is empty, set by
//   the fully pipelined datapath (32 log2 squaring stages, 14 two-stage
//   series steps).
// Reset: synchronous, active low; flushes all valid bits and the output
//   skid, and loads range -1.0 .. +1.0 and shaping exponent 1.0.
module curvature_to_false_color_core #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COLOR_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,  // curvature
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((3*COLOR_WIDTH+7)/8)*8-1:0]     out_tdata, // red, green, blue
  output logic                                   out_tuser, // range_error
  // config write port
  input  logic                                   cfg_wr_en,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]                cfg_wdata
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COLOR_WIDTH;
  localparam int PW   = $clog2(SW);
  localparam int LW   = PW + 32;           // log2 result: int.frac Q32
  localparam int OTW  = ((3*CW+7)/8)*8;
  localparam int NT   = cfc_pkg::SERIES_TERMS;
  localparam int NL   = cfc_pkg::LOG_STEPS;

  localparam logic [32:0] P1 = 33'd1 << 30;
  localparam logic [32:0] P2 = 33'd2 << 30;
  localparam logic [32:0] P3 = 33'd3 << 30;
  localparam logic [32:0] P4 = 33'd4 << 30;

  // ---------------------------------------------------------------------
  // config registers; user writes only when pipe empty (unchecked); read live
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] range_low_r, range_high_r;
  logic [15:0]          gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= SW'(-65536);
      range_high_r <= SW'(65536);
      gamma_r      <= 16'd4096;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cfc_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        cfc_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_wdata;
        cfc_pkg::CFG_SHAPING:    gamma_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipe enable: the whole pipe advances unless the output skid is full
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid_r;
  assign en        = !skid_valid_r;
  assign in_tready = en;

  function automatic logic [PW-1:0] msb_index(input logic [SW-1:0] x);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < SW; i++) begin
      if (x[i]) r = PW'(i);
    end
    return r;
  endfunction

  // stage A: capture sample
  logic                 v_a_r;
  logic signed [SW-1:0] k_a_r;

  // stage B: clamp, range checks, span
  logic                 v_b_r;
  logic signed [SW-1:0] kc_b_r;
  logic [SW-1:0]        d_b_r;
  cfc_pkg::side_t       sd_b_r;

  // stage C: numerator hi + lo - 2k
  logic                   v_c_r;
  logic signed [SW+1:0]   n_c_r;
  logic [SW-1:0]          d_c_r;
  cfc_pkg::side_t         sd_c_r;

  // stage D: magnitude and sign
  logic           v_d_r;
  logic [SW-1:0]  an_d_r, d_d_r;
  cfc_pkg::side_t sd_d_r;

  // stage E: leading one
  logic           v_e_r;
  logic [SW-1:0]  an_e_r, d_e_r;
  logic [PW-1:0]  pa_e_r, pd_e_r;
  cfc_pkg::side_t sd_e_r;

  // stage F: normalized Q31 mantissas
  logic           v_f_r;
  cfc_pkg::lane_t ld_f_r, la_f_r;
  logic [PW-1:0]  pa_f_r, pd_f_r;
  cfc_pkg::side_t sd_f_r;

  logic signed [SW:0]   span;
  logic signed [SW+1:0] n_c;
  logic signed [SW+1:0] n_abs;
  logic [PW-1:0]        sh_d, sh_a;
  logic [SW-1:0]        norm_d, norm_a;
  logic [SW+31:0]       wide_d, wide_a;

  assign span   = (SW+1)'(range_high_r) - (SW+1)'(range_low_r);
  assign n_c    = (SW+2)'(range_high_r) + (SW+2)'(range_low_r) - ((SW+2)'(kc_b_r) <<< 1);
  assign n_abs  = n_c_r[SW+1] ? -n_c_r : n_c_r;
  assign sh_d   = PW'(SW-1) - pd_e_r;
  assign sh_a   = PW'(SW-1) - pa_e_r;
  assign norm_d = d_e_r << sh_d;
  assign norm_a = an_e_r << sh_a;
  assign wide_d = {norm_d, 32'd0};
  assign wide_a = {norm_a, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_tvalid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_a_r <= in_tdata[SW-1:0];

      // clamp high first, then low; only meaningful when hi >= lo
      if (k_a_r > range_high_r) begin
        kc_b_r <= range_high_r;
      end else if (k_a_r < range_low_r) begin
        kc_b_r <= range_low_r;
      end else begin
        kc_b_r <= k_a_r;
      end
      d_b_r       <= span[SW-1:0];
      sd_b_r.err  <= range_high_r < range_low_r;
      sd_b_r.eq   <= range_high_r == range_low_r;
      sd_b_r.neg  <= 1'b0;
      sd_b_r.zero <= 1'b0;

      n_c_r  <= n_c;
      d_c_r  <= d_b_r;
      sd_c_r <= sd_b_r;

      an_d_r      <= n_abs[SW-1:0];
      d_d_r       <= d_c_r;
      sd_d_r.err  <= sd_c_r.err;
      sd_d_r.eq   <= sd_c_r.eq;
      sd_d_r.neg  <= n_c_r[SW+1];
      sd_d_r.zero <= n_c_r == '0;

      an_e_r <= an_d_r;
      d_e_r  <= d_d_r;
      pa_e_r <= msb_index(an_d_r);
      pd_e_r <= msb_index(d_d_r);
      sd_e_r <= sd_d_r;

      ld_f_r.m <= wide_d[SW+31 -: 32];
      ld_f_r.f <= '0;
      la_f_r.m <= wide_a[SW+31 -: 32];
      la_f_r.f <= '0;
      pd_f_r   <= pd_e_r;
      pa_f_r   <= pa_e_r;
      sd_f_r   <= sd_e_r;
    end
  end

  // ---------------------------------------------------------------------
  // log2 fraction: one squaring step per stage, span and |n| in parallel
  // ---------------------------------------------------------------------
  logic           v_l   [0:NL];
  cfc_pkg::lane_t ld_l  [0:NL];
  cfc_pkg::lane_t la_l  [0:NL];
  logic [PW-1:0]  pd_l  [0:NL];
  logic [PW-1:0]  pa_l  [0:NL];
  cfc_pkg::side_t sd_l  [0:NL];

  assign v_l[0]  = v_f_r;
  assign ld_l[0] = ld_f_r;
  assign la_l[0] = la_f_r;
  assign pd_l[0] = pd_f_r;
  assign pa_l[0] = pa_f_r;
  assign sd_l[0] = sd_f_r;

  for (genvar g = 0; g < NL; g++) begin : g_log
    cfc_log_step #(.PW(PW)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (v_l[g]),
      .d_i     (ld_l[g]),
      .a_i     (la_l[g]),
      .pd_i    (pd_l[g]),
      .pa_i    (pa_l[g]),
      .side_i  (sd_l[g]),
      .valid_o (v_l[g+1]),
      .d_o     (ld_l[g+1]),
      .a_o     (la_l[g+1]),
      .pd_o    (pd_l[g+1]),
      .pa_o    (pa_l[g+1]),
      .side_o  (sd_l[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // exponent magnitude: gamma * (log2 d - log2 |n|), then split int/frac
  // ---------------------------------------------------------------------
  logic                 v_g_r, v_h_r, v_i_r, v_j_r;
  logic [LW-1:0]        l_g_r;
  logic [LW+15:0]       prod_h_r;
  logic [31:0]          r_i_r;
  logic [4:0]           q_i_r, q_j_r;
  logic [29:0]          x_j_r;
  cfc_pkg::side_t       sd_g_r, sd_h_r, sd_i_r, sd_j_r;

  logic [LW-1:0]        log_d, log_a;
  logic [LW+16:0]       mag_w;
  logic [PW+4:0]        q_full;
  logic [61:0]          xprod;

  assign log_d  = {pd_l[NL], ld_l[NL].f};
  assign log_a  = {pa_l[NL], la_l[NL].f};
  assign mag_w  = (LW+17)'(prod_h_r) + (LW+17)'(2048);
  assign q_full = mag_w[LW+16:44];
  assign xprod  = 62'(r_i_r) * 62'(cfc_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
      v_h_r <= 1'b0;
      v_i_r <= 1'b0;
      v_j_r <= 1'b0;
    end else if (en) begin
      v_g_r <= v_l[NL];
      v_h_r <= v_g_r;
      v_i_r <= v_h_r;
      v_j_r <= v_i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_g_r    <= log_d - log_a;
      sd_g_r   <= sd_l[NL];
      prod_h_r <= (LW+16)'(l_g_r) * (LW+16)'(gamma_r);
      sd_h_r   <= sd_g_r;
      r_i_r    <= mag_w[43:12];
      // 31 and up all give zero after the final shift
      q_i_r    <= (q_full >= (PW+5)'(31)) ? 5'd31 : q_full[4:0];
      sd_i_r   <= sd_h_r;
      x_j_r    <= xprod[61:32];
      q_j_r    <= q_i_r;
      sd_j_r   <= sd_i_r;
    end
  end

  // ---------------------------------------------------------------------
  // e^-x series, Horner form, highest term first
  // ---------------------------------------------------------------------
  logic           v_s  [0:NT];
  logic [29:0]    x_s  [0:NT];
  logic [30:0]    p_s  [0:NT];
  logic [4:0]     q_s  [0:NT];
  cfc_pkg::side_t sd_s [0:NT];

  assign v_s[0]  = v_j_r;
  assign x_s[0]  = x_j_r;
  assign p_s[0]  = cfc_pkg::ONE_Q30;
  assign q_s[0]  = q_j_r;
  assign sd_s[0] = sd_j_r;

  for (genvar g = 0; g < NT; g++) begin : g_series
    cfc_horner_step #(.K(NT - g)) u_term (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (v_s[g]),
      .x_i     (x_s[g]),
      .p_i     (p_s[g]),
      .q_i     (q_s[g]),
      .side_i  (sd_s[g]),
      .valid_o (v_s[g+1]),
      .x_o     (x_s[g+1]),
      .p_o     (p_s[g+1]),
      .q_o     (q_s[g+1]),
      .side_o  (sd_s[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // power, hue position and ramp fractions
  // ---------------------------------------------------------------------
  logic           v_k_r, v_p_r, v_m_r;
  logic [30:0]    u_k_r;
  logic [32:0]    pos_p_r;
  logic [30:0]    fr_m_r, fg_m_r, fb_m_r;
  logic           err_m_r;
  cfc_pkg::side_t sd_k_r, sd_p_r;

  logic [32:0]    u_ext;
  logic [32:0]    fr, fg, fb;

  assign u_ext = 33'(u_k_r);

  always_comb begin
    if (pos_p_r < P1) begin
      fg = pos_p_r;
    end else if (pos_p_r < P3) begin
      fg = P1;
    end else if (pos_p_r < P4) begin
      fg = P4 - pos_p_r;
    end else begin
      fg = '0;
    end

    if (pos_p_r < P1) begin
      fr = P1;
    end else if (pos_p_r < P2) begin
      fr = P2 - pos_p_r;
    end else begin
      fr = '0;
    end

    if (pos_p_r < P2) begin
      fb = '0;
    end else if (pos_p_r < P3) begin
      fb = pos_p_r - P2;
    end else begin
      fb = P1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_k_r <= 1'b0;
      v_p_r <= 1'b0;
      v_m_r <= 1'b0;
    end else if (en) begin
      v_k_r <= v_s[NT];
      v_p_r <= v_k_r;
      v_m_r <= v_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // t == 0: u is 1 only for a zero exponent
      if (sd_s[NT].zero) begin
        u_k_r <= (gamma_r == '0) ? cfc_pkg::ONE_Q30 : '0;
      end else begin
        u_k_r <= p_s[NT] >> q_s[NT];
      end
      sd_k_r <= sd_s[NT];

      if (sd_k_r.eq) begin
        pos_p_r <= P2;
      end else if (sd_k_r.neg) begin
        pos_p_r <= (P1 - u_ext) << 1;
      end else begin
        pos_p_r <= (P1 + u_ext) << 1;
      end
      sd_p_r <= sd_k_r;

      fr_m_r  <= fr[30:0];
      fg_m_r  <= fg[30:0];
      fb_m_r  <= fb[30:0];
      err_m_r <= sd_p_r.err;
    end
  end

  // ---------------------------------------------------------------------
  // channel scaling, two stages each
  // ---------------------------------------------------------------------
  logic [CW-1:0] red, green, blue;
  logic          v_n_r, v_o_r;

  cfc_channel #(.CW(CW)) u_red (
    .clk (clk), .en (en), .f_i (fr_m_r), .err_i (err_m_r), .color_o (red)
  );
  cfc_channel #(.CW(CW)) u_green (
    .clk (clk), .en (en), .f_i (fg_m_r), .err_i (err_m_r), .color_o (green)
  );
  cfc_channel #(.CW(CW)) u_blue (
    .clk (clk), .en (en), .f_i (fb_m_r), .err_i (err_m_r), .color_o (blue)
  );

  logic err_n_r, err_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_n_r <= 1'b0;
      v_o_r <= 1'b0;
    end else if (en) begin
      v_n_r <= v_m_r;
      v_o_r <= v_n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_n_r <= err_m_r;
      err_o_r <= err_n_r;
    end
  end

  // ---------------------------------------------------------------------
  // output register plus one skid word; skid full stalls the pipe
  // ---------------------------------------------------------------------
  logic [OTW-1:0] res_word;
  logic [OTW-1:0] out_data_r, skid_data_r;
  logic           out_user_r, skid_user_r;
  logic           out_valid_r;
  logic           arrive;

  assign res_word = OTW'({blue, green, red});
  assign arrive   = en && v_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (arrive) begin
      if (out_valid_r && !out_tready) begin
        skid_data_r <= res_word;
        skid_user_r <= err_o_r;
      end else begin
        out_data_r <= res_word;
        out_user_r <= err_o_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/cfc_checker.sv =====
`include "curvature_to_false_color_core_macros.svh"

module cfc_checker #(
  parameter int COLOR_WIDTH = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((3*COLOR_WIDTH+7)/8)*8-1:0]  out_tdata,
  input logic                                out_tuser
);

  localparam int CW = COLOR_WIDTH;

  // stalled result word holds
  `CFC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // inverted range gives black
  `CFC_ASSERT_IMP(a_err_black, out_tvalid && out_tuser, out_tdata[3*CW-1:0] == '0)

  // valid range: every channel is nonzero, as the 1/20 floor implies
  `CFC_ASSERT_IMP(a_no_black, out_tvalid && !out_tuser, (out_tdata[CW-1:0] != '0) && (out_tdata[2*CW-1:CW] != '0) && (out_tdata[3*CW-1:2*CW] != '0))

  // input side only backs off after the output stalled
  `CFC_ASSERT_IMP(a_ready_drop, $fell(in_tready), $past(out_tvalid && !out_tready))

endmodule

bind curvature_to_false_color_core cfc_checker #(.COLOR_WIDTH(COLOR_WIDTH)) u_cfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // index 3 is not a register; writes to it must be dropped
  localparam logic [cfc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned LN2_FRAC = 64'd744261118;
  localparam int EXP_TERMS = 14;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 150;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        err;
  } color_t;

  // one line of the directed sequence: a register write or a sample
  typedef struct {
    bit                            is_cfg;
    logic [cfc_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                   val;
    bit                            typed;  // want holds a hand-derived color
    color_t                        want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;     // curvature
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;         // red, green, blue
  logic out_tuser;                // range_error
  logic cfg_wr_en = 1'b0;
  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_index = cfc_pkg::CFG_RANGE_LOW;
  logic [31:0] cfg_wdata = '0;

  // shadow copy of the block's registers
  logic signed [31:0] range_lo_q = -32'sd65536;
  logic signed [31:0] range_hi_q = 32'sd65536;
  logic [15:0] gamma_q = 16'd4096;

  color_t expected_colors[$];
  row_t directed_rows[$];
  int mismatches = 0;
  int words_sent = 0;
  int colors_seen = 0;
  int error_colors = 0;
  bit quiet = 1'b0;   // no idling on either side
  int ready_hold = 0;

  curvature_to_false_color_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // log2 of x >= 1 in Q32; fraction from repeated squaring of a Q31 mantissa
  function automatic longint unsigned log2_fixed(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned f;
    p = 63;
    f = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    return (longint'(p) << 32) | f;
  endfunction

  // 2^-mag, mag in Q32, result Q30; fraction via series for e^-x
  function automatic longint unsigned pow2_neg(longint unsigned mag);
    longint unsigned q;
    longint unsigned x;
    longint unsigned p;
    q = mag >> 32;
    p = Q30_ONE;
    if (q >= 31) return 0;
    x = ((mag & 64'hFFFF_FFFF) * LN2_FRAC) >> 32;
    for (int t = EXP_TERMS; t >= 1; t--)
      p = Q30_ONE - ((x * p) >> 30) / longint'(t);
    return p >> q;
  endfunction

  // Q30 ramp fraction to a 16-bit channel between 1/20 and 19/20
  function automatic logic [15:0] ramp_to_channel(longint unsigned f);
    longint unsigned v;
    v = (((Q30_ONE + 18 * f) << 16) + 10 * Q30_ONE) / (20 * Q30_ONE);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic color_t predict_color(logic [31:0] sample);
    longint k;
    longint lo;
    longint hi;
    longint n;
    longint unsigned d;
    longint unsigned an;
    longint unsigned u;
    longint unsigned pos;
    longint unsigned fr;
    longint unsigned fg;
    longint unsigned fb;
    color_t c;
    k = longint'(signed'(sample));
    lo = longint'(range_lo_q);
    hi = longint'(range_hi_q);
    c = '0;
    if (hi < lo) begin
      c.err = 1'b1;
      return c;
    end
    if (k > hi) k = hi;
    if (k < lo) k = lo;
    if (hi == lo) begin
      pos = 2 * Q30_ONE;
    end else begin
      d = hi - lo;
      n = hi + lo - 2 * k;
      an = (n < 0) ? -n : n;
      if (an == 0)
        u = (gamma_q == 0) ? Q30_ONE : 0;
      else
        u = pow2_neg(((log2_fixed(d) - log2_fixed(an)) * gamma_q + 2048) >> 12);
      pos = (n < 0) ? 2 * (Q30_ONE - u) : 2 * (Q30_ONE + u);
    end
    // hue position 0..4 in Q30 -> ramp fractions
    if (pos < Q30_ONE) fg = pos;
    else if (pos < 3 * Q30_ONE) fg = Q30_ONE;
    else if (pos < 4 * Q30_ONE) fg = 4 * Q30_ONE - pos;
    else fg = 0;
    if (pos < Q30_ONE) fr = Q30_ONE;
    else if (pos < 2 * Q30_ONE) fr = 2 * Q30_ONE - pos;
    else fr = 0;
    if (pos < 2 * Q30_ONE) fb = 0;
    else if (pos < 3 * Q30_ONE) fb = pos - 2 * Q30_ONE;
    else fb = Q30_ONE;
    c.red = ramp_to_channel(fr);
    c.green = ramp_to_channel(fg);
    c.blue = ramp_to_channel(fb);
    return c;
  endfunction

  // ---------------------------------------------------------------- drivers
  // register writes only once the pipe has drained
  task automatic write_reg(logic [cfc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      cfc_pkg::CFG_RANGE_LOW:  range_lo_q = val;
      cfc_pkg::CFG_RANGE_HIGH: range_hi_q = val;
      cfc_pkg::CFG_SHAPING:    gamma_q = val[15:0];
      default: ;
    endcase
  endtask

  // one word; an idle burst may come first, and the expectation is queued
  // at the accepting edge
  task automatic send_word(logic [31:0] sample, bit typed, color_t want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_colors.push_back(typed ? want : predict_color(sample));
    words_sent++;
  endtask

  // sample picked relative to the current range, plus full-scale noise
  function automatic logic [31:0] pick_sample();
    longint lo;
    longint hi;
    lo = longint'(range_lo_q);
    hi = longint'(range_hi_q);
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2, 3: if (hi > lo) return 32'(lo + longint'($urandom) % (hi - lo + 1));
            else return $urandom;
      4: return ($urandom_range(0, 1) == 0) ? range_lo_q : range_hi_q;
      5: return 32'($urandom_range(0, 4000)) - 32'd2000;
      default: return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("tb_top: mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got,
             want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_tvalid && out_tready) begin
      colors_seen++;
      if (out_tuser) error_colors++;
      if (expected_colors.size() == 0) begin
        $display("tb_top: unexpected word at %0t", $realtime);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        if (out_tdata[15:0] !== want.red) report_mismatch("red", out_tdata[15:0], want.red);
        if (out_tdata[31:16] !== want.green)
          report_mismatch("green", out_tdata[31:16], want.green);
        if (out_tdata[47:32] !== want.blue)
          report_mismatch("blue", out_tdata[47:32], want.blue);
        if (out_tuser !== want.err) report_mismatch("range_error", out_tuser, want.err);
      end
    end
  end

  // ---------------------------------------------------------------- directed rows
  function automatic color_t rgb(int r, int g, int b, bit e);
    color_t c;
    c.red = 16'(r);
    c.green = 16'(g);
    c.blue = 16'(b);
    c.err = e;
    return c;
  endfunction

  task automatic add_cfg(logic [cfc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    directed_rows.push_back('{1'b1, idx, val, 1'b0, '0});
  endtask

  task automatic add_word(logic [31:0] sample);
    directed_rows.push_back('{1'b0, cfc_pkg::CFG_RANGE_LOW, sample, 1'b0, '0});
  endtask

  task automatic add_known(logic [31:0] sample, color_t want);
    directed_rows.push_back('{1'b0, cfc_pkg::CFG_RANGE_LOW, sample, 1'b1, want});
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    logic [31:0] lo_val;
    logic [31:0] hi_val;
    logic [15:0] g_val;
    logic [31:0] span;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset range -1..+1, gamma 1: top of range is red, bottom blue, middle green
    add_known(32'h0000_0000, rgb(3277, 62259, 3277, 0));
    add_known(32'h7FFF_FFFF, rgb(62259, 3277, 3277, 0));
    add_known(32'h8000_0000, rgb(3277, 3277, 62259, 0));
    add_word(32'h0001_0000);
    add_word(32'hFFFF_0000);
    add_word(32'h0000_8000);
    add_word(32'h0000_0001);
    // zero gamma: center jumps to 240 degrees
    add_cfg(cfc_pkg::CFG_SHAPING, 32'd0);
    add_known(32'h0000_0000, rgb(3277, 3277, 62259, 0));
    add_word(32'h0000_0064);
    // huge gamma pushes the power toward zero
    add_cfg(cfc_pkg::CFG_SHAPING, 32'h0000_FFFF);
    add_word(32'h0000_03E8);
    add_word(32'hFFFF_8000);
    // empty range always gives green
    add_cfg(cfc_pkg::CFG_RANGE_LOW, 32'd5);
    add_cfg(cfc_pkg::CFG_RANGE_HIGH, 32'd5);
    add_known(32'h8000_0000, rgb(3277, 62259, 3277, 0));
    // inverted range: black plus error flag
    add_cfg(cfc_pkg::CFG_RANGE_LOW, 32'd10);
    add_known(32'h0000_0007, rgb(0, 0, 0, 1));
    add_cfg(CFG_SPARE, 32'hDEAD_BEEF);
    add_known(32'h7FFF_FFFF, rgb(0, 0, 0, 1));
    // full-scale range
    add_cfg(cfc_pkg::CFG_RANGE_LOW, 32'h8000_0000);
    add_cfg(cfc_pkg::CFG_RANGE_HIGH, 32'h7FFF_FFFF);
    add_cfg(cfc_pkg::CFG_SHAPING, 32'd4096);
    add_known(32'h7FFF_FFFF, rgb(62259, 3277, 3277, 0));
    add_word(32'h0000_0000);
    add_word(32'h8000_0000);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_reg(directed_rows[i].idx, directed_rows[i].val);
      else send_word(directed_rows[i].val, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0: begin lo_val = 32'h8000_0000; hi_val = 32'h7FFF_FFFF; end
        1: begin lo_val = $urandom; hi_val = lo_val; end
        2: begin hi_val = $urandom; lo_val = hi_val + 32'd1 + $urandom_range(0, 1000); end
        3: begin lo_val = $urandom; hi_val = $urandom; end
        default: begin
          span = $urandom_range(1, 32'h0100_0000);
          lo_val = 32'($urandom_range(0, 32'h0100_0000)) - span;
          hi_val = lo_val + span + $urandom_range(0, 32'h0010_0000);
        end
      endcase
      case ($urandom_range(0, 5))
        0: g_val = 16'd0;
        1: g_val = 16'hFFFF;
        2: g_val = 16'd4096;
        3: g_val = 16'($urandom_range(1, 16384));
        default: g_val = 16'($urandom);
      endcase
      if (ph >= PHASES - 2) quiet = 1'b1;
      write_reg(cfc_pkg::CFG_RANGE_LOW, lo_val);
      write_reg(cfc_pkg::CFG_RANGE_HIGH, hi_val);
      write_reg(cfc_pkg::CFG_SHAPING, {16'd0, g_val});
      for (int i = 0; i < WORDS_PER_PHASE; i++) send_word(pick_sample(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d curvature words over %0d register settings incl. extremes,",
             words_sent, PHASES + 8);
    $display("tb_top: %0d colors checked, %0d with range error, %0d mismatches",
             colors_seen, error_colors, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/cfc_pkg.sv
src/cfc_log_step.sv
src/cfc_horner_step.sv
src/cfc_channel.sv
src/curvature_to_false_color_core.sv
src/cfc_checker.sv
dv/tb_top.sv
